// ===== src/ordered_value_list_defines.svh =====
// Assertion macros used by the ordered value list checker
`ifndef ORDERED_VALUE_LIST_DEFINES_SVH
`define ORDERED_VALUE_LIST_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define OLIST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define OLIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/olist_pkg.sv =====
// Types and constants of the ordered value list
package olist_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POS_OUT_W   = 4;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned RES_DATA_W  = 16;

  typedef enum logic [KIND_W-1:0] {
    OP_APPEND = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // search token walking down the chain
  typedef struct packed {
    logic               act;
    logic               hit;
    logic [VALUE_W-1:0] key;
  } token_t;

  // strobes broadcast to every cell
  typedef struct packed {
    logic append_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

// ===== src/olist_cell.sv =====
// One list cell: holds a slot, compares the passing token, shifts on delete
module olist_cell
  import olist_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_ctrl_t                   ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic [$clog2(DEPTH)-1:0]     shift_pos,
  input  logic [VALUE_W-1:0]           wr_value,
  input  logic [VALUE_W-1:0]           nbr_slot,
  input  token_t                       tok_i,
  input  logic [$clog2(DEPTH)-1:0]     pos_i,
  output token_t                       tok_o,
  output logic [$clog2(DEPTH)-1:0]     pos_o,
  output logic [VALUE_W-1:0]           slot
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic live;
  logic match;

  assign live  = CW'(IDX) < count;
  assign match = tok_i.act && !tok_i.hit && live && (slot == tok_i.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_o.act <= 1'b0;
    end else begin
      tok_o.act <= tok_i.act;
      tok_o.hit <= tok_i.hit | match;
      tok_o.key <= tok_i.key;
      pos_o     <= match ? PW'(IDX) : pos_i;
    end
  end

  // append writes the tail slot; delete pulls the upper neighbor down
  always_ff @(posedge clk) begin
    if (ctrl.append_en && (CW'(IDX) == count)) begin
      slot <= wr_value;
    end else if (ctrl.shift_en && (PW'(IDX) >= shift_pos)) begin
      slot <= nbr_slot;
    end
  end

endmodule

// ===== src/ordered_value_list.sv =====
// Ordered value list: top level with request control and the cell chain
// Append and clear: the request moves the control to ST_DONE, and the result is then loaded
//   into the output register, raising m_tvalid. Find and delete: the request sends a search token
//   down the cell chain, one cell per cycle; the result is loaded once it leaves the last cell.
// One request is in work at a time. A finished result waits in the output register while the
//   next request is taken; a result held by m_tready low delays the following one by the stall.
// rst (synchronous) empties the list and drops m_tvalid; slot contents are not cleared.
module ordered_value_list
  import olist_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
  input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [RES_DATA_W-1:0] m_tdata,   // [0] found, [4:1] position, [9:5] count,
                                           // [10] empty_res, [15:11] zero
  output logic [STATUS_W-1:0]   m_tuser    // [1:0] status
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  state_t              state;
  state_t              state_next;
  logic [CW-1:0]       count;
  logic                is_del;
  status_t             res_status;
  logic                res_found;
  logic [PW-1:0]       res_pos;

  logic                accept;
  kind_t               in_kind;
  logic                full;
  logic                search_done;
  logic                load_out;
  cell_ctrl_t          cell_ctrl;
  token_t              tok_in;

  token_t              tok  [DEPTH];
  logic [PW-1:0]       pos  [DEPTH];
  logic [VALUE_W-1:0]  slot [DEPTH];

  assign in_kind = kind_t'(s_tuser);
  assign full    = count == CW'(DEPTH);

  // ---------------- control: next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == OP_FIND || in_kind == OP_DELETE) begin
            state_next = ST_SEARCH;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SEARCH: begin
        if (tok[DEPTH-1].act) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- control: outputs ----------------
  always_comb begin
    s_tready            = (state == ST_IDLE);
    accept              = s_tvalid && (state == ST_IDLE);
    search_done         = (state == ST_SEARCH) && tok[DEPTH-1].act;
    load_out            = (state == ST_DONE) && (!m_tvalid || m_tready);
    cell_ctrl.append_en = accept && (in_kind == OP_APPEND) && !full;
    cell_ctrl.shift_en  = search_done && tok[DEPTH-1].hit && is_del;
    tok_in.act          = accept && (in_kind == OP_FIND || in_kind == OP_DELETE);
    tok_in.hit          = 1'b0;
    tok_in.key          = s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      case (in_kind)
        OP_APPEND: if (!full) count <= count + CW'(1);
        OP_CLEAR:  count <= '0;
        default:   count <= count;
      endcase
    end else if (cell_ctrl.shift_en) begin
      count <= count - CW'(1);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      is_del     <= (in_kind == OP_DELETE);
      res_found  <= 1'b0;
      res_pos    <= '0;
      res_status <= (in_kind == OP_APPEND && full) ? STAT_FULL : STAT_OK;
    end else if (search_done) begin
      res_found  <= tok[DEPTH-1].hit;
      res_pos    <= tok[DEPTH-1].hit ? pos[DEPTH-1] : '0;
      res_status <= tok[DEPTH-1].hit ? STAT_OK : STAT_NOT_FOUND;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= res_status;
      m_tdata <= {5'b0, (count == '0), COUNT_OUT_W'(count), POS_OUT_W'(res_pos), res_found};
    end
  end

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    token_t             c_tok_i;
    logic [PW-1:0]      c_pos_i;
    logic [VALUE_W-1:0] c_nbr;

    if (i == 0) begin : g_head
      assign c_tok_i = tok_in;
      assign c_pos_i = '0;
    end else begin : g_body
      assign c_tok_i = tok[i-1];
      assign c_pos_i = pos[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign c_nbr = slot[i];
    end else begin : g_inner
      assign c_nbr = slot[i+1];
    end

    olist_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .count     (count),
      .shift_pos (pos[DEPTH-1]),
      .wr_value  (s_tdata),
      .nbr_slot  (c_nbr),
      .tok_i     (c_tok_i),
      .pos_i     (c_pos_i),
      .tok_o     (tok[i]),
      .pos_o     (pos[i]),
      .slot      (slot[i])
    );
  end

endmodule

// ===== src/olist_checker.sv =====
// Port-level checker for the ordered value list, bound to the top level
`include "ordered_value_list_defines.svh"

module olist_checker
  import olist_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [RES_DATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]   m_tuser
);

  // a match is only reported with an ok status
  `OLIST_ASSERT_IMPL(a_found_ok, m_tvalid && m_tdata[0], m_tuser == STAT_OK, "found without ok status")

  // no match means position zero
  `OLIST_ASSERT_IMPL(a_pos_zero, m_tvalid && !m_tdata[0], m_tdata[4:1] == 4'd0, "position set without match")

  // empty flag agrees with count (count field wraps only for deep lists)
  `OLIST_ASSERT_IMPL(a_empty, m_tvalid, (DEPTH >= 32) || (m_tdata[10] == (m_tdata[9:5] == 5'd0)), "empty flag disagrees with count")

  // a stalled result holds
  `OLIST_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

endmodule

bind ordered_value_list olist_checker #(.DEPTH(DEPTH)) u_olist_checker (.*);
